// ----- src/bwt_rotation_sort_top_defines.svh -----
// Assertion macros used by the rotation sort checker.
`ifndef BWT_ROTATION_SORT_TOP_DEFINES_SVH
`define BWT_ROTATION_SORT_TOP_DEFINES_SVH

// Condition must never hold outside reset.
`define BWT_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

// Antecedent in one cycle requires the consequent in the next.
`define BWT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("expected follow-up not seen");

`endif

// ----- src/bwt_rs_pkg.sv -----
// Shared constants, types and state codes of the rotation sort block.
package bwt_rs_pkg;

  localparam int MAX_TEXT = 63;
  localparam int IDX_W    = 6;
  localparam int SYM_W    = 8;
  localparam int OUT_W    = 32;
  localparam logic [SYM_W-1:0] SENTINEL = 8'd36;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_CMP,
    ST_PLACE,
    ST_FETCH,
    ST_TEXT,
    ST_CAP,
    ST_SHOW
  } state_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [SYM_W-1:0] wr_data;
    logic [IDX_W-1:0] rd_addr_a;
    logic [IDX_W-1:0] rd_addr_b;
    logic [IDX_W-1:0] length;
  } text_req_t;

  typedef struct packed {
    logic [SYM_W-1:0] byte_a;
    logic [SYM_W-1:0] byte_b;
  } text_rsp_t;

  typedef struct packed {
    logic             cap;
    logic [IDX_W-1:0] rank;
    logic [IDX_W-1:0] start;
    logic [SYM_W-1:0] first_sym;
    logic [SYM_W-1:0] last_sym;
    logic             last_row;
    logic             truncated;
  } row_t;

endpackage

// ----- src/bwt_rs_text_store.sv -----
// Text memory with two registered read ports and sentinel substitution.
module bwt_rs_text_store (
  input  logic                  clk,
  input  bwt_rs_pkg::text_req_t req,
  output bwt_rs_pkg::text_rsp_t rsp
);
  import bwt_rs_pkg::*;

  logic [SYM_W-1:0] mem [0:MAX_TEXT-1];
  logic [SYM_W-1:0] data_a;
  logic [SYM_W-1:0] data_b;
  logic             sent_a;
  logic             sent_b;

  // Write one symbol, read two positions; a position at the text end is '$'
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    data_a <= mem[req.rd_addr_a];
    data_b <= mem[req.rd_addr_b];
    sent_a <= (req.rd_addr_a >= req.length);
    sent_b <= (req.rd_addr_b >= req.length);
  end

  assign rsp.byte_a = sent_a ? SENTINEL : data_a;
  assign rsp.byte_b = sent_b ? SENTINEL : data_b;

endmodule

// ----- src/bwt_rs_seq.sv -----
// Sequencer: loads the text, ranks every rotation with one byte comparator, emits rows.
module bwt_rs_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_last,
  input  logic [bwt_rs_pkg::SYM_W-1:0] in_symbol,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bwt_rs_pkg::text_req_t text_req,
  input  bwt_rs_pkg::text_rsp_t text_rsp,
  output bwt_rs_pkg::row_t      row
);
  import bwt_rs_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] len;
  logic             ovf;
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] pa;
  logic [IDX_W-1:0] pb;
  logic [IDX_W-1:0] rank;
  logic [IDX_W-1:0] r;
  logic [IDX_W-1:0] s_q;
  logic [IDX_W-1:0] ord_q;
  logic [IDX_W-1:0] order_mem [0:(1 << IDX_W)-1];
  logic             in_acc;
  logic             b_less;
  logic             b_more;
  logic             cmp_done;
  logic             cmp_before;

  // Step a position round the rotation of len+1 symbols
  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p,
                                                 input logic [IDX_W-1:0] last);
    wrap_inc = (p == last) ? '0 : p + 1'b1;
  endfunction

  assign in_acc = in_valid && in_ready;

  // Shared comparator: rotation j against rotation i, one byte per pass
  assign b_less     = text_rsp.byte_b < text_rsp.byte_a;
  assign b_more     = text_rsp.byte_b > text_rsp.byte_a;
  assign cmp_done   = b_less || b_more || (k == len);
  assign cmp_before = b_less || (!b_more && (j < i));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:  if (in_acc && in_last) state_next = ST_READ;
      ST_READ: begin
        if (j == i) state_next = (j == len) ? ST_PLACE : ST_READ;
        else        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (cmp_done && (j == len)) state_next = ST_PLACE;
        else                        state_next = ST_READ;
      end
      ST_PLACE: state_next = (i == len) ? ST_FETCH : ST_READ;
      ST_FETCH: state_next = ST_TEXT;
      ST_TEXT:  state_next = ST_CAP;
      ST_CAP:   state_next = ST_SHOW;
      ST_SHOW: begin
        if (out_ready) state_next = (r == len) ? ST_LOAD : ST_FETCH;
      end
      default:  state_next = ST_LOAD;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready           = (state == ST_LOAD);
    out_valid          = (state == ST_SHOW);
    text_req.wr_en     = in_acc && (len < IDX_W'(MAX_TEXT));
    text_req.wr_addr   = len;
    text_req.wr_data   = in_symbol;
    text_req.length    = len;
    text_req.rd_addr_a = pa;
    text_req.rd_addr_b = pb;
    if (state == ST_TEXT) begin
      text_req.rd_addr_a = ord_q;
      text_req.rd_addr_b = (ord_q == '0) ? len : ord_q - 1'b1;
    end
    row.cap       = (state == ST_CAP);
    row.rank      = r;
    row.start     = s_q;
    row.first_sym = text_rsp.byte_a;
    row.last_sym  = text_rsp.byte_b;
    row.last_row  = (r == len);
    row.truncated = ovf;
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      len   <= '0;
      ovf   <= 1'b0;
      i     <= '0;
      j     <= '0;
      k     <= '0;
      pa    <= '0;
      pb    <= '0;
      rank  <= '0;
      r     <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (len < IDX_W'(MAX_TEXT)) len <= len + 1'b1;
            else                        ovf <= 1'b1;
            if (in_last) begin
              i    <= '0;
              j    <= '0;
              k    <= '0;
              pa   <= '0;
              pb   <= '0;
              rank <= '0;
            end
          end
        end
        ST_READ: begin
          // skip the rotation against itself
          if (j == i) begin
            j  <= j + 1'b1;
            k  <= '0;
            pa <= i;
            pb <= j + 1'b1;
          end
        end
        ST_CMP: begin
          if (cmp_done) begin
            if (cmp_before) rank <= rank + 1'b1;
            j  <= j + 1'b1;
            k  <= '0;
            pa <= i;
            pb <= j + 1'b1;
          end else begin
            k  <= k + 1'b1;
            pa <= wrap_inc(pa, len);
            pb <= wrap_inc(pb, len);
          end
        end
        ST_PLACE: begin
          i    <= i + 1'b1;
          j    <= '0;
          k    <= '0;
          rank <= '0;
          pa   <= i + 1'b1;
          pb   <= '0;
          r    <= '0;
        end
        ST_FETCH: ;
        ST_TEXT:  ;
        ST_CAP:   ;
        ST_SHOW: begin
          if (out_ready) begin
            r <= r + 1'b1;
            if (r == len) begin
              len <= '0;
              ovf <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Hold the rotation start of the row being emitted
  always_ff @(posedge clk) begin
    if (state == ST_TEXT) s_q <= ord_q;
  end

  // Order memory: place each rotation at its rank, read back in rank order
  always_ff @(posedge clk) begin
    if (state == ST_PLACE) order_mem[rank] <= i;
    ord_q <= order_mem[r];
  end

endmodule

// ----- src/bwt_rotation_sort_top.sv -----
// Top level of the rotation sort: stream ports, output register, sub-blocks.
// Loading accepts one symbol item per cycle; the item marked last starts the sort.
// Sorting ranks each of the n = length+1 rotations against all others through one
// byte comparator fed by a two-port text memory, each byte pair read and then compared;
// rows then go out in rank order: fetch, text read, capture, show, held while stalled.
// Reset clears the sequencer, length and overflow flag; the stores need no clearing.
module bwt_rotation_sort_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] symbol
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [5:0] row_rank, [11:6] rotation_start,
                                 // [19:12] first_symbol, [27:20] last_symbol, rest zero
  output logic        m_tlast,   // last_row
  output logic [0:0]  m_tuser    // [0] truncated
);
  import bwt_rs_pkg::*;

  text_req_t text_req;
  text_rsp_t text_rsp;
  row_t      row;

  bwt_rs_text_store u_text (
    .clk (clk),
    .req (text_req),
    .rsp (text_rsp)
  );

  bwt_rs_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_last   (s_tlast),
    .in_symbol (s_tdata[SYM_W-1:0]),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .text_req  (text_req),
    .text_rsp  (text_rsp),
    .row       (row)
  );

  // Capture one finished row into the output register
  always_ff @(posedge clk) begin
    if (row.cap) begin
      m_tdata <= {4'b0000, row.last_sym, row.first_sym, row.start, row.rank};
      m_tlast <= row.last_row;
      m_tuser <= row.truncated;
    end
  end

endmodule

// ----- src/bwt_rs_chk.sv -----
// Port-level checker for the rotation sort top level, bound to it.
`include "bwt_rotation_sort_top_defines.svh"

module bwt_rs_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  // Loading and emitting never overlap
  `BWT_ASSERT_NEVER(a_no_overlap, s_tready && m_tvalid)

  // Final text item stops further input while the sort runs
  `BWT_ASSERT_NEXT(a_sort_starts, s_tvalid && s_tready && s_tlast, !s_tready)

  // After the final row nothing more is offered
  `BWT_ASSERT_NEXT(a_run_ends, m_tvalid && m_tready && m_tlast, !m_tvalid)

  // A stalled row holds
  `BWT_ASSERT_NEXT(a_row_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind bwt_rotation_sort_top bwt_rs_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
